// ===== rtl/fcfl_pkg.sv =====
// shared types, constants and codes for the fixed chunk free list allocator
// no dependencies; imported by every module of the block
package fcfl_pkg;

    // pool geometry
    localparam int POOL_CHUNKS = 256;
    localparam int ADDR_W      = $clog2(POOL_CHUNKS);
    localparam int IDX_W       = $clog2(POOL_CHUNKS + 1);

    typedef logic [ADDR_W-1:0] chunk_addr_t;
    typedef logic [IDX_W-1:0]  chunk_idx_t;

    // end-of-list marker
    localparam chunk_idx_t EMPTY_CODE = IDX_W'(POOL_CHUNKS);

    // reset contents of the list cache: head at chunk 0, then 1, then 2
    localparam chunk_idx_t HEAD_RESET = IDX_W'(0);
    localparam chunk_idx_t LINK_RESET = IDX_W'(1);
    localparam chunk_idx_t PREF_RESET = IDX_W'(2);

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SHIFT = 2'd1;

    localparam logic [31:0] POOL_BASE_RESET  = 32'd0;
    localparam logic [3:0]  UNIT_SHIFT_RESET = 4'd6;

    // request and result beats
    typedef struct packed {
        logic        command;
        logic [15:0] request_size;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] chunk_address;
        logic [1:0]  status;
    } rsp_t;

    // write request into the link table
    typedef struct packed {
        logic        en;
        chunk_addr_t addr;
        chunk_idx_t  data;
    } link_wr_t;

endpackage

// ===== rtl/fcfl_link_ram.sv =====
// next-index link table of the free list, one write and one registered read port
// depends on fcfl_pkg; entries never written read back as their own index plus one
module fcfl_link_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  fcfl_pkg::link_wr_t  wr,
    input  fcfl_pkg::chunk_addr_t rd_addr,
    output fcfl_pkg::chunk_idx_t  rd_data
);
    import fcfl_pkg::*;

    chunk_idx_t               link_mem [POOL_CHUNKS];
    logic [POOL_CHUNKS-1:0]   vld_reg;
    logic [POOL_CHUNKS-1:0]   vld_next;
    chunk_idx_t               rd_data_reg;
    chunk_addr_t              rd_addr_reg;
    logic                     rd_vld_reg;

    // storage array and its read register
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            link_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= link_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // written-entry flags
    always_comb
    begin
        vld_next = vld_reg;
        if (wr.en)
        begin
            vld_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // untouched entries still hold their ascending reset link
    assign rd_data = rd_vld_reg ? rd_data_reg : (IDX_W'(rd_addr_reg) + IDX_W'(1));

endmodule

// ===== rtl/fcfl_core.sv =====
// free list controller: head, its link and a prefetched second link, plus request decode
// depends on fcfl_pkg and fcfl_link_ram
module fcfl_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  fcfl_pkg::req_t req,
    input  logic [31:0]    cfg_base,
    input  logic [3:0]     cfg_shift,
    output fcfl_pkg::rsp_t result
);
    import fcfl_pkg::*;

    chunk_idx_t  head_reg;
    chunk_idx_t  head_next;
    chunk_idx_t  link_reg;
    chunk_idx_t  link_next;
    chunk_idx_t  pref_reg;
    chunk_idx_t  pref_next;
    logic        pref_sel_reg;
    logic        pref_sel_next;
    chunk_idx_t  pref_eff;
    chunk_idx_t  ram_rd_data;
    link_wr_t    ram_wr;

    logic [16:0] chunk_bytes;
    logic        too_large;
    logic        head_empty;
    logic [31:0] offset;
    logic [31:0] chunk_wide;
    logic        outside;
    chunk_addr_t chunk;
    chunk_idx_t  chunk_idx;
    logic [31:0] alloc_addr;
    logic        pop;
    logic        push;

    // request decode
    assign chunk_bytes = 17'(1) << cfg_shift;
    assign too_large   = {1'b0, req.request_size} > chunk_bytes;
    assign head_empty  = head_reg >= EMPTY_CODE;
    assign offset      = req.free_address - cfg_base;
    assign chunk_wide  = offset >> cfg_shift;
    assign outside     = chunk_wide >= 32'(POOL_CHUNKS);
    assign chunk       = chunk_wide[ADDR_W-1:0];
    assign chunk_idx   = IDX_W'(chunk);
    assign alloc_addr  = cfg_base + (32'(head_reg[ADDR_W-1:0]) << cfg_shift);

    assign pop  = fire && (req.command == CMD_ALLOC) && !too_large && !head_empty;
    assign push = fire && (req.command == CMD_FREE) && !outside;

    // second link comes from the table read right after a pop
    assign pref_eff = pref_sel_reg ? ram_rd_data : pref_reg;

    // result of the current beat
    always_comb
    begin
        result.chunk_address = '0;
        result.status        = ST_OK;
        if (req.command == CMD_ALLOC)
        begin
            if (too_large)
            begin
                result.status = ST_TOO_LARGE;
            end
            else if (head_empty)
            begin
                result.status = ST_EXHAUSTED;
            end
            else
            begin
                result.chunk_address = alloc_addr;
            end
        end
        else if (outside)
        begin
            result.status = ST_OUTSIDE;
        end
    end

    // list cache update
    always_comb
    begin
        head_next     = head_reg;
        link_next     = link_reg;
        pref_next     = pref_reg;
        pref_sel_next = 1'b0;
        if (pop)
        begin
            head_next     = link_reg;
            link_next     = pref_eff;
            pref_sel_next = 1'b1;
        end
        else if (push)
        begin
            head_next = chunk_idx;
            link_next = head_reg;
            // freeing the head again makes it link to itself
            pref_next = (chunk_idx == head_reg) ? head_reg : link_reg;
        end
        else if (pref_sel_reg)
        begin
            pref_next = ram_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= HEAD_RESET;
            link_reg     <= LINK_RESET;
            pref_reg     <= PREF_RESET;
            pref_sel_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            link_reg     <= link_next;
            pref_reg     <= pref_next;
            pref_sel_reg <= pref_sel_next;
        end
    end

    // link table: push writes, the prefetch reads one step ahead
    assign ram_wr.en   = push;
    assign ram_wr.addr = chunk;
    assign ram_wr.data = head_reg;

    fcfl_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_addr (pref_eff[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // a pop moves the cached link into the head
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> head_reg == $past(link_reg))
        else $error("head did not advance to the cached link after a pop");

    // the table read is used only in the cycle after a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        pref_sel_reg |-> $past(pop))
        else $error("prefetch taken from the table without a preceding pop");

    // a rejected request leaves the list alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !pop && !push) |=>
            (head_reg == $past(head_reg)) && (link_reg == $past(link_reg)))
        else $error("list changed on a rejected request");

endmodule

// ===== rtl/fixed_chunk_free_list_allocator_top.sv =====
// top level of the fixed chunk free list allocator: request and result registers, config
// depends on fcfl_pkg and fcfl_core
//
// Pool allocator for 256 equal chunks of 2**unit_shift bytes starting at pool_base.
// An allocate beat pops the head of the free list and returns its byte address; a free
// beat rounds any address inside the pool down to its chunk and pushes that chunk.
// Every request beat gives exactly one result beat, passing through the request register
// and then the result register. One request is taken every cycle while the result side
// does not stall: the head, its link and a second link are kept in registers, and the
// link table read issued during a pop arrives in time for a pop in the very next cycle.
// The link table starts in its ascending reset order right after reset, with no clearing
// pass. Double frees are not detected. Configuration writes are taken every cycle
// (cfg_ready is always high) and should only be made while no request is in flight.
module fixed_chunk_free_list_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  fcfl_pkg::req_t                  req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output fcfl_pkg::rsp_t                  rsp_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import fcfl_pkg::*;

    logic        req_vld_reg;
    logic        req_vld_next;
    req_t        req_data_reg;
    logic        rsp_vld_reg;
    logic        rsp_vld_next;
    rsp_t        rsp_data_reg;
    rsp_t        core_result;
    logic        advance;
    logic        req_take;
    logic [31:0] base_reg;
    logic [31:0] base_next;
    logic [3:0]  shift_reg;
    logic [3:0]  shift_next;

    // handshake control
    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign req_vld_next = req_take || (req_vld_reg && !advance);
    assign rsp_vld_next = advance || (rsp_vld_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // request and result beat registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_data_reg <= req_data;
        end
        if (advance)
        begin
            rsp_data_reg <= core_result;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_data_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_next  = base_reg;
        shift_next = shift_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_BASE:  base_next  = cfg_data;
                CFG_UNIT_SHIFT: shift_next = cfg_data[3:0];
                default:        base_next  = base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= POOL_BASE_RESET;
            shift_reg <= UNIT_SHIFT_RESET;
        end
        else
        begin
            base_reg  <= base_next;
            shift_reg <= shift_next;
        end
    end

    // free list controller
    fcfl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .req       (req_data_reg),
        .cfg_base  (base_reg),
        .cfg_shift (shift_reg),
        .result    (core_result)
    );

    // a request that moves on shows up as a result beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_vld_reg)
        else $error("processed request produced no result beat");

endmodule

// ===== tb/sv/tb_fixed_chunk_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for fixed_chunk_free_list_allocator_top
// depends on fcfl_pkg and the allocator rtl; a free list mirror predicts the non-fixed replies
module tb_fixed_chunk_free_list_allocator_top;
    import fcfl_pkg::*;

    localparam int RESET_CYCLES     = 11;
    localparam int PHASES           = 6;
    localparam int PHASE_ITEMS      = 280;
    localparam int QUIET_PHASE      = 3;
    localparam int STALL_PCT        = 28;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HANG_LIMIT       = 5000;
    localparam int SHOWN_MISMATCHES = 10;

    // unmapped register slots, writes there must leave the block alone
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef struct {
        req_t beat;
        bit   fixed;
        rsp_t want;
    } step_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    always #2 clk = ~clk;

    fixed_chunk_free_list_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the allocator state and registers
    logic [31:0] cur_base;
    logic [3:0]  cur_shift;
    chunk_idx_t  list_head;
    chunk_idx_t  list_link [POOL_CHUNKS];

    rsp_t        due_replies [$];
    chunk_idx_t  live_chunks [$];
    int          idle_pct   = STALL_PCT;
    int          mismatches = 0;
    int          hang_count = 0;
    rsp_t        oldest;

    // one request against the mirrored free list, state updated in place
    function automatic rsp_t pool_reply(req_t beat);
        rsp_t        reply;
        logic [31:0] unit;
        logic [31:0] chunk;
        reply = '0;
        unit  = 32'd1 << cur_shift;
        if (beat.command == CMD_ALLOC)
        begin
            if ({16'd0, beat.request_size} > unit)
                reply.status = ST_TOO_LARGE;
            else if (list_head >= POOL_CHUNKS)
                reply.status = ST_EXHAUSTED;
            else
            begin
                reply.chunk_address = cur_base + ({{(32-IDX_W){1'b0}}, list_head} << cur_shift);
                reply.status        = ST_OK;
                list_head           = list_link[list_head[ADDR_W-1:0]];
            end
        end
        else
        begin
            // any address in a chunk rounds down to that chunk
            chunk = (beat.free_address - cur_base) >> cur_shift;
            if (chunk >= POOL_CHUNKS)
                reply.status = ST_OUTSIDE;
            else
            begin
                list_link[chunk[ADDR_W-1:0]] = list_head;
                list_head                    = chunk[IDX_W-1:0];
                reply.status                 = ST_OK;
            end
        end
        return reply;
    endfunction

    function automatic step_row_t step_row(logic cmd, logic [15:0] size, logic [31:0] addr,
                                           bit fixed, logic [31:0] want_addr,
                                           logic [1:0] want_status);
        step_row_t row;
        row.beat.command       = cmd;
        row.beat.request_size  = size;
        row.beat.free_address  = addr;
        row.fixed              = fixed;
        row.want.chunk_address = want_addr;
        row.want.status        = want_status;
        return row;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] seen);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch on %s: expected %h, got %h", what, want, seen);
    endfunction

    // present one request beat and hold it until taken
    task automatic issue(input req_t beat, input bit fixed, input rsp_t want, output rsp_t got);
        chunk_idx_t  popped;
        logic [31:0] chunk;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        popped = list_head;
        got    = pool_reply(beat);
        // keep the set of chunks held by the traffic up to date
        if (beat.command == CMD_ALLOC && got.status == ST_OK)
            live_chunks.push_back(popped);
        else if (beat.command == CMD_FREE && got.status == ST_OK)
        begin
            chunk = (beat.free_address - cur_base) >> cur_shift;
            for (int i = 0; i < live_chunks.size(); i++)
            begin
                if (live_chunks[i] == chunk[IDX_W-1:0])
                begin
                    live_chunks.delete(i);
                    break;
                end
            end
        end
        due_replies.push_back(fixed ? want : got);
        req_valid <= 1'b1;
        req_data  <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // register write, only once every reply is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        req_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_POOL_BASE)
            cur_base = value;
        else if (idx == CFG_UNIT_SHIFT)
            cur_shift = value[3:0];
    endtask

    // result side stalls at random
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < idle_pct);
    end

    // compare each result beat with the oldest pending reply
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_replies.size() == 0)
                note_mismatch("unexpected result beat", 32'd0, rsp_data.chunk_address);
            else
            begin
                oldest = due_replies.pop_front();
                if (rsp_data.chunk_address !== oldest.chunk_address)
                    note_mismatch("chunk_address", oldest.chunk_address,
                                  rsp_data.chunk_address);
                if (rsp_data.status !== oldest.status)
                    note_mismatch("status", {30'd0, oldest.status}, {30'd0, rsp_data.status});
            end
        end
    end

    // hang detection: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        step_row_t   rows [$];
        req_t        beat;
        rsp_t        got;
        logic [31:0] unit;
        logic [31:0] addr;
        chunk_idx_t  pick;
        int          roll;
        int          dry_hits;
        int          mode_items;
        bit          filling;
        logic [31:0] phase_base  [PHASES];
        logic [3:0]  phase_shift [PHASES];

        // reset state of the mirror
        cur_base  = POOL_BASE_RESET;
        cur_shift = UNIT_SHIFT_RESET;
        list_head = HEAD_RESET;
        for (int i = 0; i < POOL_CHUNKS - 1; i++)
            list_link[i] = chunk_idx_t'(i + 1);
        list_link[POOL_CHUNKS - 1] = EMPTY_CODE;
        filling    = 1'b1;
        dry_hits   = 0;
        mode_items = 0;

        // register settings per phase, wrapping pools and the shift extremes among them
        phase_base[0]  = $urandom;       phase_shift[0] = 4'd0;
        phase_base[1]  = 32'hFFFF_FFFF;  phase_shift[1] = 4'd12;
        phase_base[2]  = $urandom;       phase_shift[2] = 4'd15;
        phase_base[3]  = 32'h0000_0000;  phase_shift[3] = 4'd3;
        phase_base[4]  = 32'hFFFF_8000;  phase_shift[4] = 4'd14;
        phase_base[5]  = $urandom;       phase_shift[5] = 4'($urandom_range(15));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats under the reset settings: 64 byte chunks from address zero
        rows.push_back(step_row(CMD_ALLOC, 16'd0,     32'h0,         1'b1, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd64,    32'h0,         1'b1, 32'h40, ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd65,    32'h0,         1'b1, 32'h0,  ST_TOO_LARGE));
        rows.push_back(step_row(CMD_ALLOC, 16'hFFFF,  32'h0,         1'b1, 32'h0,  ST_TOO_LARGE));
        rows.push_back(step_row(CMD_FREE,  16'd0,     32'h3F,        1'b1, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd1,     32'h0,         1'b1, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_FREE,  16'd0,     32'h4000,      1'b1, 32'h0,  ST_OUTSIDE));
        rows.push_back(step_row(CMD_FREE,  16'd0,     32'hFFFF_FFFF, 1'b1, 32'h0,  ST_OUTSIDE));
        rows.push_back(step_row(CMD_FREE,  16'd0,     32'h40,        1'b1, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_FREE,  16'd0,     32'h0,         1'b1, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd64,    32'h0,         1'b0, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd0,     32'h0,         1'b0, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd2,     32'h0,         1'b0, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_FREE,  16'hFFFF,  32'h41,        1'b1, 32'h0,  ST_OK));
        rows.push_back(step_row(CMD_ALLOC, 16'd64,    32'hFFFF_FFFF, 1'b0, 32'h0,  ST_OK));
        foreach (rows[i])
            issue(rows[i].beat, rows[i].fixed, rows[i].want, got);

        // random phases: fill the pool until it runs dry, then drain it, over and over
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(CFG_POOL_BASE, phase_base[ph]);
            write_reg(CFG_UNIT_SHIFT, ($urandom & 32'hFFFF_FFF0) | {28'd0, phase_shift[ph]});
            write_reg(ph[0] ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO, $urandom);
            idle_pct = (ph == QUIET_PHASE) ? 0 : STALL_PCT;
            unit     = 32'd1 << cur_shift;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                beat.command      = CMD_ALLOC;
                beat.request_size = 16'($urandom);
                beat.free_address = $urandom;
                roll              = $urandom_range(99);
                if (roll < 3)
                begin
                    // allocate with any size at all
                    beat.command = CMD_ALLOC;
                end
                else if (roll < 6)
                begin
                    // free outside the pool
                    beat.command = CMD_FREE;
                    case ($urandom_range(2))
                        0: addr = cur_base - 32'd1;
                        1: addr = cur_base + (32'(POOL_CHUNKS) << cur_shift)
                                  + $urandom_range(unit - 1, 0);
                        default:
                        begin
                            addr = $urandom;
                            if (((addr - cur_base) >> cur_shift) < POOL_CHUNKS)
                                addr = cur_base - 32'd1;
                        end
                    endcase
                    beat.free_address = addr;
                end
                else if (live_chunks.size() == 0 || roll < (filling ? 90 : 20))
                begin
                    beat.command = CMD_ALLOC;
                    case ($urandom_range(9))
                        0:       beat.request_size = unit[15:0] + 16'd1;
                        1:       beat.request_size = unit[15:0];
                        default: beat.request_size = 16'($urandom_range(unit, 0));
                    endcase
                end
                else
                begin
                    // release a held chunk through any byte inside it
                    pick              = live_chunks[$urandom_range(live_chunks.size() - 1)];
                    beat.command      = CMD_FREE;
                    beat.free_address = cur_base + ({{(32-IDX_W){1'b0}}, pick} << cur_shift)
                                        + $urandom_range(unit - 1, 0);
                end
                issue(beat, 1'b0, '0, got);
                mode_items++;
                if (got.status == ST_EXHAUSTED)
                    dry_hits++;
                if (filling && (dry_hits >= 3 || mode_items > 600))
                begin
                    filling    = 1'b0;
                    mode_items = 0;
                end
                else if (!filling && live_chunks.size() <= $urandom_range(16))
                begin
                    filling    = 1'b1;
                    dry_hits   = 0;
                    mode_items = 0;
                end
            end
        end

        // double free last, since it loops the list for good
        if (live_chunks.size() != 0)
        begin
            pick              = live_chunks[0];
            beat              = '0;
            beat.command      = CMD_FREE;
            beat.free_address = cur_base + ({{(32-IDX_W){1'b0}}, pick} << cur_shift);
            issue(beat, 1'b0, '0, got);
            issue(beat, 1'b0, '0, got);
        end
        beat         = '0;
        beat.command = CMD_ALLOC;
        repeat (3) issue(beat, 1'b0, '0, got);

        // wait out the last replies
        req_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
